// ----- design/ray_box_slab_test_macros.svh -----
// Assertion macros for the ray box slab test
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH

// Property checked on every clock edge outside reset
`define RBST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ray_box_slab_test check failed");

// Condition implies consequence in the next cycle
`define RBST_ASSERT_NEXT(lbl, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("ray_box_slab_test check failed");

`endif

// ----- design/rbst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rbst_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int LIM_W      = 17;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int AXES       = 3;
    localparam int DIV_SPS    = 2;
    localparam int DIV_STAGES = COORD_W / DIV_SPS;
    localparam int FOLD_STAGES = AXES;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-1:0]        ucoord_t;

    localparam coord_t T_HI = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t T_LO = {1'b1, {(COORD_W-1){1'b0}}};

    // One divider lane: overflow and sign flags, remainder and the shared dividend/quotient word
    typedef struct packed {
        logic    ovf;
        logic    neg;
        ucoord_t rem;
        ucoord_t lq;
    } lane_t;

    typedef struct packed {
        lane_t   lo;
        lane_t   hi;
        ucoord_t den;
        logic    par;
        logic    in_slab;
    } axis_t;

    typedef axis_t [AXES-1:0] work_t;

    // One restoring division step
    function automatic lane_t div_step(input lane_t l, input ucoord_t den);
        logic [COORD_W:0] t;
        logic [COORD_W:0] d;
        lane_t r;
        r = l;
        t = {l.rem, l.lq[COORD_W-1]};
        d = t - {1'b0, den};
        if (t >= {1'b0, den})
        begin
            r.rem = d[COORD_W-1:0];
            r.lq  = {l.lq[COORD_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[COORD_W-1:0];
            r.lq  = {l.lq[COORD_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Apply sign and saturate a finished quotient
    function automatic coord_t sat_q(input lane_t l);
        coord_t r;
        if (!l.neg)
            r = (l.ovf || l.lq[COORD_W-1]) ? T_HI : coord_t'(l.lq);
        else
            r = (l.ovf || l.lq[COORD_W-1]) ? T_LO : coord_t'(-l.lq);
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/ray_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ray_req_if;
    import rbst_pkg::*;

    logic   valid;
    logic   ready;
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t box_lo_x;
    coord_t box_lo_y;
    coord_t box_lo_z;
    coord_t box_hi_x;
    coord_t box_hi_y;
    coord_t box_hi_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                  output ready);
endinterface
`default_nettype wire

// ----- design/ray_res_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ray_res_if;
    import rbst_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [COORD_W-2:0] t_enter;
    coord_t            t_exit;

    modport source (output valid, hit, t_enter, t_exit, input ready);
    modport sink (input valid, hit, t_enter, t_exit, output ready);
endinterface
`default_nettype wire

// ----- design/rbst_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbst_prep (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [rbst_pkg::LIM_W-1:0] limit,
    ray_req_if.sink                   req,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rbst_pkg::work_t           out_work
);
    import rbst_pkg::*;

    logic   valid_reg;
    work_t  work_reg;
    work_t  work_next;
    logic   adv;
    coord_t o [AXES];
    coord_t d [AXES];
    coord_t lo [AXES];
    coord_t hi [AXES];

    assign o[0] = req.origin_x;  assign o[1] = req.origin_y;  assign o[2] = req.origin_z;
    assign d[0] = req.dir_x;     assign d[1] = req.dir_y;     assign d[2] = req.dir_z;
    assign lo[0] = req.box_lo_x; assign lo[1] = req.box_lo_y; assign lo[2] = req.box_lo_z;
    assign hi[0] = req.box_hi_x; assign hi[1] = req.box_hi_y; assign hi[2] = req.box_hi_z;

    // Stage may load when empty or when its content moves on
    assign adv       = !valid_reg || out_ready;
    assign req.ready = adv;

    // Plane differences, magnitudes, parallel test and divider set-up
    always_comb
    begin
        logic signed [DIFF_W-1:0] dlo;
        logic signed [DIFF_W-1:0] dhi;
        logic [DIFF_W-1:0]        mlo;
        logic [DIFF_W-1:0]        mhi;
        ucoord_t                  dm;
        ucoord_t                  tlo;
        ucoord_t                  thi;
        work_next = '0;
        for (int a = 0; a < AXES; a++)
        begin
            dlo = {lo[a][COORD_W-1], lo[a]} - {o[a][COORD_W-1], o[a]};
            dhi = {hi[a][COORD_W-1], hi[a]} - {o[a][COORD_W-1], o[a]};
            mlo = dlo[DIFF_W-1] ? DIFF_W'(-dlo) : DIFF_W'(dlo);
            mhi = dhi[DIFF_W-1] ? DIFF_W'(-dhi) : DIFF_W'(dhi);
            dm  = d[a][COORD_W-1] ? ucoord_t'(-d[a]) : ucoord_t'(d[a]);
            tlo = ucoord_t'(mlo[DIFF_W-1:COORD_W-FRAC_W]);
            thi = ucoord_t'(mhi[DIFF_W-1:COORD_W-FRAC_W]);
            work_next[a].den     = dm;
            work_next[a].par     = (dm == '0) || (dm < ucoord_t'(limit));
            work_next[a].in_slab = (o[a] >= lo[a]) && (o[a] <= hi[a]);
            work_next[a].lo.ovf  = tlo >= dm;
            work_next[a].lo.neg  = dlo[DIFF_W-1] ^ d[a][COORD_W-1];
            work_next[a].lo.rem  = (tlo >= dm) ? '0 : tlo;
            work_next[a].lo.lq   = {mlo[COORD_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            work_next[a].hi.ovf  = thi >= dm;
            work_next[a].hi.neg  = dhi[DIFF_W-1] ^ d[a][COORD_W-1];
            work_next[a].hi.rem  = (thi >= dm) ? '0 : thi;
            work_next[a].hi.lq   = {mhi[COORD_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && req.valid)
            work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;
endmodule
`default_nettype wire

// ----- design/rbst_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbst_div (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire rbst_pkg::work_t in_work,
    output logic            out_valid,
    input  wire logic       out_ready,
    output rbst_pkg::work_t out_work
);
    import rbst_pkg::*;

    logic  valid_reg [DIV_STAGES];
    work_t work_reg  [DIV_STAGES];
    work_t work_next [DIV_STAGES];
    logic  stage_in_valid [DIV_STAGES];
    logic  adv [DIV_STAGES];

    // Per-stage advance: empty or downstream moving
    always_comb
    begin
        adv[DIV_STAGES-1] = !valid_reg[DIV_STAGES-1] || out_ready;
        for (int i = DIV_STAGES - 2; i >= 0; i--)
            adv[i] = !valid_reg[i] || adv[i+1];
    end

    // Each stage takes DIV_SPS quotient bits on all six lanes
    always_comb
    begin
        work_t w;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (i == 0)
            begin
                w = in_work;
                stage_in_valid[i] = in_valid;
            end
            else
            begin
                w = work_reg[i-1];
                stage_in_valid[i] = valid_reg[i-1];
            end
            for (int s = 0; s < DIV_SPS; s++)
                for (int a = 0; a < AXES; a++)
                begin
                    w[a].lo = div_step(w[a].lo, w[a].den);
                    w[a].hi = div_step(w[a].hi, w[a].den);
                end
            work_next[i] = w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                if (adv[i])
                    valid_reg[i] <= stage_in_valid[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_STAGES; i++)
            if (adv[i] && stage_in_valid[i])
                work_reg[i] <= work_next[i];
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_work  = work_reg[DIV_STAGES-1];
endmodule
`default_nettype wire

// ----- design/rbst_fold.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbst_fold (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire rbst_pkg::work_t in_work,
    ray_res_if.source       res
);
    import rbst_pkg::*;

    typedef struct packed {
        logic   par;
        logic   in_slab;
        coord_t t1;
        coord_t t2;
    } tax_t;

    typedef struct packed {
        logic               hit;
        logic               done;
        coord_t             tmin;
        coord_t             tmax;
        tax_t [AXES-1:0]    ax;
    } fold_t;

    logic  valid_reg [FOLD_STAGES];
    fold_t fold_reg  [FOLD_STAGES];
    fold_t fold_next [FOLD_STAGES];
    logic  stage_in_valid [FOLD_STAGES];
    logic  adv [FOLD_STAGES];

    always_comb
    begin
        adv[FOLD_STAGES-1] = !valid_reg[FOLD_STAGES-1] || res.ready;
        for (int i = FOLD_STAGES - 2; i >= 0; i--)
            adv[i] = !valid_reg[i] || adv[i+1];
    end

    // Stage k folds axis k into the running interval
    always_comb
    begin
        fold_t  f;
        coord_t a1;
        coord_t a2;
        for (int k = 0; k < FOLD_STAGES; k++)
        begin
            a1 = '0;
            a2 = '0;
            if (k == 0)
            begin
                f.hit  = 1'b1;
                f.done = 1'b0;
                f.tmin = '0;
                f.tmax = T_HI;
                for (int a = 0; a < AXES; a++)
                begin
                    f.ax[a].par     = in_work[a].par;
                    f.ax[a].in_slab = in_work[a].in_slab;
                    f.ax[a].t1      = sat_q(in_work[a].lo);
                    f.ax[a].t2      = sat_q(in_work[a].hi);
                end
                stage_in_valid[k] = in_valid;
            end
            else
            begin
                f = fold_reg[k-1];
                stage_in_valid[k] = valid_reg[k-1];
            end
            if (!f.done)
            begin
                if (f.ax[k].par)
                begin
                    if (!f.ax[k].in_slab)
                    begin
                        f.hit  = 1'b0;
                        f.done = 1'b1;
                    end
                end
                else
                begin
                    // order the two plane distances
                    if (f.ax[k].t1 > f.ax[k].t2)
                    begin
                        a1 = f.ax[k].t2;
                        a2 = f.ax[k].t1;
                    end
                    else
                    begin
                        a1 = f.ax[k].t1;
                        a2 = f.ax[k].t2;
                    end
                    if (a1 > f.tmin)
                        f.tmin = a1;
                    if (a2 < f.tmax)
                        f.tmax = a2;
                    if (f.tmin > f.tmax)
                    begin
                        f.hit  = 1'b0;
                        f.done = 1'b1;
                    end
                end
            end
            fold_next[k] = f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FOLD_STAGES; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < FOLD_STAGES; i++)
                if (adv[i])
                    valid_reg[i] <= stage_in_valid[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FOLD_STAGES; i++)
            if (adv[i] && stage_in_valid[i])
                fold_reg[i] <= fold_next[i];
    end

    assign in_ready    = adv[0];
    assign res.valid   = valid_reg[FOLD_STAGES-1];
    assign res.hit     = fold_reg[FOLD_STAGES-1].hit;
    assign res.t_enter = fold_reg[FOLD_STAGES-1].tmin[COORD_W-2:0];
    assign res.t_exit  = fold_reg[FOLD_STAGES-1].tmax;
endmodule
`default_nettype wire

// ----- design/ray_box_slab_test.sv -----
// Ray versus axis-aligned box slab test, signed Q16.16; t_enter is unsigned Q15.16.
// req: one request per ray/box pair (origin, direction, box corners),
//   valid/ready handshake. res: hit flag, entry and exit distance.
// cfg_we/cfg_wdata write the parallel limit; write only while idle.
// Pipeline: one set-up stage, 16 divider stages (two quotient bits per
//   stage for all six plane distances) and three fold stages, one per
//   axis.
// Throughput: one request per cycle while res is not stalled, set by the fully pipelined divider.
// Reset clears all stage valid bits and sets the parallel limit to 1.
// When res is stalled, items close up behind the result register;
//   req.ready drops only when every stage is occupied.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_test (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [rbst_pkg::LIM_W-1:0] cfg_wdata,
    ray_req_if.sink                         req,
    ray_res_if.source                       res
);
    import rbst_pkg::*;
    `include "ray_box_slab_test_macros.svh"

    logic [LIM_W-1:0] limit_reg;
    logic             prep_valid;
    logic             div_ready;
    work_t            prep_work;
    logic             div_valid;
    logic             fold_ready;
    work_t            div_work;

    // Parallel limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIM_W'(1);
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    rbst_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .req       (req),
        .out_valid (prep_valid),
        .out_ready (div_ready),
        .out_work  (prep_work)
    );

    rbst_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (div_ready),
        .in_work   (prep_work),
        .out_valid (div_valid),
        .out_ready (fold_ready),
        .out_work  (div_work)
    );

    rbst_fold u_fold (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .in_ready (fold_ready),
        .in_work  (div_work),
        .res      (res)
    );

    // Checks
    `RBST_ASSERT(a_hit_order, (res.valid && res.hit) |-> ($signed({1'b0, res.t_enter}) <= res.t_exit))
    `RBST_ASSERT_NEXT(a_cfg_write, cfg_we, limit_reg == $past(cfg_wdata))
    `RBST_ASSERT_NEXT(a_res_held, res.valid && !res.ready, res.valid)
endmodule
`default_nettype wire
